>>> src/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked implication, disabled while in reset.
`define JDSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold at a clock edge.
`define JDSP_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define JDSP_ASSERT(label, clk, rst_n, prop, msg)
`define JDSP_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> src/jdsp_pkg.sv
// Types, constants and helpers for the DHT segment parser.
package jdsp_pkg;

    localparam int NUM_TABLES_DEF = 4;
    localparam int MAX_VALUES     = 256;
    localparam int TBL_BYTES      = 273;
    localparam int NUM_COUNTS     = 16;
    localparam int VAL_BASE       = 17;
    localparam int TBL_IDX_MAX_W  = 3;
    localparam int STO_ADDR_MAX_W = 12;
    localparam int STG_ADDR_W     = 9;
    localparam int ALU_W          = 16;
    localparam int STORE_DEPTH_DEF = 2 * NUM_TABLES_DEF * TBL_BYTES;

    localparam logic [ALU_W-1:0]      LEN_HDR_BYTES = 16'd2;
    localparam logic [ALU_W-1:0]      BOUND_LIMIT   = 16'd17;
    localparam logic [ALU_W-1:0]      MAX_VAL_CNT   = 16'd256;
    localparam logic [STG_ADDR_W-1:0] CP_LAST       = 9'd273;
    localparam logic [7:0]            AC_CLASS_MASK = 8'h10;

    typedef enum logic [1:0] {
        STAT_BUSY = 2'd0,
        STAT_DONE = 2'd1,
        STAT_ERR  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_HEADER,
        PH_COUNTS,
        PH_VALUES,
        PH_END
    } phase_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_INC,
        SQ_CNT_SUB,
        SQ_CNT_CHK1,
        SQ_CNT_CHK2,
        SQ_VCMP,
        SQ_VSUB,
        SQ_FIN,
        SQ_COPY,
        SQ_BOUND,
        SQ_RD_ADDR,
        SQ_RD_DATA,
        SQ_OUT
    } seq_state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } alu_rsp_t;

    typedef struct packed {
        logic                  we;
        logic                  clr;
        logic [STG_ADDR_W-1:0] waddr;
        logic [7:0]            wdata;
        logic [STG_ADDR_W-1:0] raddr;
    } stg_ctl_t;

    typedef struct packed {
        logic                      we;
        logic [STO_ADDR_MAX_W-1:0] addr;
        logic [7:0]                data;
    } sto_wr_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] seg_byte;
        logic       seg_start;
        logic       rd_class;
        logic [1:0] rd_table;
        logic [8:0] rd_pos;
    } dht_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       committed;
        logic       committed_class;
        logic [1:0] committed_index;
    } dht_out_t;

    // idx * 273 as shift-add (256 + 16 + 1)
    function automatic logic [STO_ADDR_MAX_W-1:0] tbl_base(input logic [TBL_IDX_MAX_W-1:0] idx);
        return {1'b0, idx, 8'h00} + {5'b0, idx, 4'h0} + {9'b0, idx};
    endfunction

endpackage

>>> src/jpeg_dht_segment_parser_core.sv
// Top level: DHT segment parser sequencer with shared ALU, staging area and table store.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------
//  item     | in        | item_valid / item_stall    | jdsp_pkg::dht_in_t
//  result   | out       | result_valid / result_stall| jdsp_pkg::dht_out_t
//
// One item in flight; item_stall is high from acceptance until the result transfer.
// Per item: marker, length high, table header and ignored bytes run EXEC then OUT; length low
// adds BOUND, count INC, value VCMP, sixteenth count CNT_SUB to CNT_CHK2; a read runs RD_ADDR,
// RD_DATA, OUT; one ALU op a cycle. Commit: 274 staging-to-store copy steps, one write port.
// Reset is asynchronous; staging valid bits clear at once, no clearing pass.
// A stalled result holds its payload until result_stall drops.
module jpeg_dht_segment_parser_core #(
    parameter int NUM_TABLES = jdsp_pkg::NUM_TABLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  jdsp_pkg::dht_in_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output jdsp_pkg::dht_out_t result
);
    import jdsp_pkg::*;

    localparam int STORE_DEPTH = 2 * NUM_TABLES * TBL_BYTES;
    localparam int IDX_W       = $clog2(2 * NUM_TABLES);

    // sequencer and parse state
    seq_state_t  state_reg,  state_next;
    phase_t      phase_reg,  phase_next;
    status_t     status_reg, status_next;
    logic [8:0]  bp_reg,     bp_next;
    logic [15:0] rem_reg,    rem_next;
    logic [7:0]  hdr_reg,    hdr_next;
    logic [11:0] vc_reg,     vc_next;
    logic [8:0]  cp_reg,     cp_next;
    logic [IDX_W-1:0] cidx_reg, cidx_next;

    // latched item and result payload
    dht_in_t     item_reg,   item_next;
    logic [7:0]  rdd_reg,    rdd_next;
    logic        cm_reg,     cm_next;
    logic        cmc_reg,    cmc_next;
    logic [1:0]  cmi_reg,    cmi_next;

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    stg_ctl_t    stg_ctl;
    logic [7:0]  stg_rdata;
    sto_wr_t     sto_wr;
    logic [STO_ADDR_MAX_W-1:0] sto_raddr;
    logic [7:0]  sto_rdata;

    logic        item_xfer;
    logic [7:0]  seg_b;
    logic [7:0]  tbl_num;
    logic [IDX_W-1:0] commit_idx;
    logic [IDX_W-1:0] rd_idx;
    logic        rd_ok;
    logic [STO_ADDR_MAX_W-1:0] commit_base;
    logic [STO_ADDR_MAX_W-1:0] rd_base;
    logic [8:0]  cp_prev;

    assign item_stall   = (state_reg != SQ_IDLE);
    assign item_xfer    = item_valid && !item_stall;
    assign result_valid = (state_reg == SQ_OUT);

    assign result.status          = status_reg;
    assign result.read_data       = rdd_reg;
    assign result.committed       = cm_reg;
    assign result.committed_class = cmc_reg;
    assign result.committed_index = cmi_reg;

    assign seg_b   = item_reg.seg_byte;
    // table number is the header byte with the class bit cleared
    assign tbl_num = hdr_reg & ~AC_CLASS_MASK;
    assign commit_idx = hdr_reg[4] ? IDX_W'(NUM_TABLES) + IDX_W'(tbl_num)
                                   : IDX_W'(tbl_num);
    assign rd_idx  = item_reg.rd_class ? IDX_W'(NUM_TABLES) + IDX_W'(item_reg.rd_table)
                                       : IDX_W'(item_reg.rd_table);
    assign rd_ok   = ({1'b0, item_reg.rd_table} < 3'(NUM_TABLES)) &&
                     (item_reg.rd_pos < 9'(TBL_BYTES));
    assign commit_base = tbl_base(TBL_IDX_MAX_W'(cidx_reg));
    assign rd_base     = tbl_base(TBL_IDX_MAX_W'(rd_idx));
    assign cp_prev     = cp_reg - 9'd1;

    jdsp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    jdsp_stage u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stg_ctl),
        .rdata (stg_rdata)
    );

    jdsp_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .wr    (sto_wr),
        .raddr (sto_raddr),
        .rdata (sto_rdata)
    );

    // ALU operand selection, shared by next-state and datapath logic
    always_comb
    begin
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
        unique case (state_reg)
            SQ_EXEC:
            begin
                if (phase_reg == PH_LEN_LO)
                begin
                    alu_req = '{op: ALU_SUB, a: {rem_reg[15:8], seg_b}, b: LEN_HDR_BYTES};
                end
                else if (phase_reg == PH_COUNTS)
                begin
                    alu_req = '{op: ALU_ADD, a: {4'b0, vc_reg}, b: {8'b0, seg_b}};
                end
                else if (phase_reg == PH_VALUES)
                begin
                    alu_req = '{op: ALU_ADD, a: {7'b0, bp_reg}, b: 16'd1};
                end
            end
            SQ_INC:      alu_req = '{op: ALU_ADD, a: {7'b0, bp_reg}, b: 16'd1};
            SQ_CNT_SUB:  alu_req = '{op: ALU_SUB, a: rem_reg, b: BOUND_LIMIT};
            SQ_CNT_CHK1: alu_req = '{op: ALU_SUB, a: MAX_VAL_CNT, b: {4'b0, vc_reg}};
            SQ_CNT_CHK2: alu_req = '{op: ALU_SUB, a: rem_reg, b: {4'b0, vc_reg}};
            SQ_VCMP:     alu_req = '{op: ALU_SUB, a: {7'b0, bp_reg}, b: {4'b0, vc_reg}};
            SQ_VSUB:     alu_req = '{op: ALU_SUB, a: rem_reg, b: {4'b0, vc_reg}};
            SQ_FIN:      alu_req = '{op: ALU_SUB, a: {8'b0, tbl_num}, b: 16'(NUM_TABLES)};
            SQ_BOUND:    alu_req = '{op: ALU_SUB, a: rem_reg, b: BOUND_LIMIT};
            default:     alu_req = '{op: ALU_ADD, a: '0, b: '0};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = item.kind ? SQ_RD_ADDR : SQ_EXEC;
                end
            end
            SQ_EXEC:
            begin
                state_next = SQ_OUT;
                if (!item_reg.seg_start)
                begin
                    unique case (phase_reg)
                        PH_LEN_LO: state_next = alu_rsp.borrow ? SQ_OUT : SQ_BOUND;
                        PH_COUNTS: state_next = (bp_reg >= 9'(NUM_COUNTS)) ? SQ_CNT_SUB
                                                                           : SQ_INC;
                        PH_VALUES: state_next = SQ_VCMP;
                        default:   state_next = SQ_OUT;
                    endcase
                end
            end
            SQ_INC:      state_next = SQ_OUT;
            SQ_CNT_SUB:  state_next = SQ_CNT_CHK1;
            SQ_CNT_CHK1: state_next = alu_rsp.borrow ? SQ_OUT : SQ_CNT_CHK2;
            SQ_CNT_CHK2:
            begin
                if (alu_rsp.borrow || vc_reg != '0)
                begin
                    state_next = SQ_OUT;
                end
                else
                begin
                    state_next = SQ_FIN;
                end
            end
            SQ_VCMP:     state_next = alu_rsp.borrow ? SQ_OUT : SQ_VSUB;
            SQ_VSUB:     state_next = SQ_FIN;
            SQ_FIN:      state_next = alu_rsp.borrow ? SQ_COPY : SQ_OUT;
            SQ_COPY:     state_next = (cp_reg == CP_LAST) ? SQ_BOUND : SQ_COPY;
            SQ_BOUND:    state_next = SQ_OUT;
            SQ_RD_ADDR:  state_next = SQ_RD_DATA;
            SQ_RD_DATA:  state_next = SQ_OUT;
            SQ_OUT:      state_next = result_stall ? SQ_OUT : SQ_IDLE;
            default:     state_next = SQ_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        bp_next     = bp_reg;
        rem_next    = rem_reg;
        hdr_next    = hdr_reg;
        vc_next     = vc_reg;
        cp_next     = cp_reg;
        cidx_next   = cidx_reg;
        item_next   = item_reg;
        rdd_next    = rdd_reg;
        cm_next     = cm_reg;
        cmc_next    = cmc_reg;
        cmi_next    = cmi_reg;
        stg_ctl     = '{we: 1'b0, clr: 1'b0, waddr: '0, wdata: seg_b, raddr: '0};
        sto_wr      = '{we: 1'b0, addr: commit_base + 12'(cp_prev), data: stg_rdata};
        sto_raddr   = rd_base + 12'(item_reg.rd_pos);

        unique case (state_reg)
            SQ_IDLE:
            begin
                if (item_xfer)
                begin
                    item_next = item;
                    rdd_next  = '0;
                    cm_next   = 1'b0;
                    cmc_next  = 1'b0;
                    cmi_next  = '0;
                end
            end
            SQ_EXEC:
            begin
                if (item_reg.seg_start)
                begin
                    // restart: byte taken as the first marker byte
                    stg_ctl.clr = 1'b1;
                    status_next = STAT_BUSY;
                    phase_next  = PH_SKIP;
                    bp_next     = 9'd1;
                    rem_next    = '0;
                    hdr_next    = '0;
                    vc_next     = '0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_SKIP:
                        begin
                            bp_next    = 9'd2;
                            phase_next = PH_LEN_HI;
                        end
                        PH_LEN_HI:
                        begin
                            rem_next   = {seg_b, 8'h00};
                            bp_next    = 9'd3;
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            bp_next = 9'd4;
                            if (alu_rsp.borrow)
                            begin
                                // length below 2
                                rem_next    = {rem_reg[15:8], seg_b};
                                status_next = STAT_ERR;
                                phase_next  = PH_END;
                            end
                            else
                            begin
                                rem_next = alu_rsp.res;
                            end
                        end
                        PH_HEADER:
                        begin
                            hdr_next   = seg_b;
                            bp_next    = 9'd1;
                            vc_next    = '0;
                            phase_next = PH_COUNTS;
                        end
                        PH_COUNTS:
                        begin
                            stg_ctl.we    = 1'b1;
                            stg_ctl.waddr = bp_reg;
                            vc_next       = alu_rsp.res[11:0];
                        end
                        PH_VALUES:
                        begin
                            stg_ctl.we    = 1'b1;
                            stg_ctl.waddr = 9'(VAL_BASE) + {1'b0, bp_reg[7:0]};
                            bp_next       = alu_rsp.res[8:0];
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            SQ_INC:
            begin
                bp_next = alu_rsp.res[8:0];
            end
            SQ_CNT_SUB:
            begin
                rem_next = alu_rsp.res;
            end
            SQ_CNT_CHK1:
            begin
                if (alu_rsp.borrow)
                begin
                    status_next = STAT_ERR;
                    phase_next  = PH_END;
                end
            end
            SQ_CNT_CHK2:
            begin
                if (alu_rsp.borrow)
                begin
                    status_next = STAT_ERR;
                    phase_next  = PH_END;
                end
                else if (vc_reg != '0)
                begin
                    bp_next    = '0;
                    phase_next = PH_VALUES;
                end
            end
            SQ_VSUB:
            begin
                rem_next = alu_rsp.res;
            end
            SQ_FIN:
            begin
                if (alu_rsp.borrow)
                begin
                    cidx_next = commit_idx;
                    cp_next   = '0;
                end
                else
                begin
                    // table number out of range, nothing committed
                    status_next = STAT_ERR;
                    phase_next  = PH_END;
                end
            end
            SQ_COPY:
            begin
                // read staging at cp, write the byte read last cycle
                stg_ctl.raddr = cp_reg;
                sto_wr.we     = (cp_reg != '0);
                if (cp_reg == CP_LAST)
                begin
                    cm_next  = 1'b1;
                    cmc_next = hdr_reg[4];
                    cmi_next = tbl_num[1:0];
                end
                else
                begin
                    cp_next = cp_reg + 9'd1;
                end
            end
            SQ_BOUND:
            begin
                if (rem_reg == '0)
                begin
                    status_next = STAT_DONE;
                    phase_next  = PH_END;
                end
                else if (alu_rsp.borrow)
                begin
                    status_next = STAT_ERR;
                    phase_next  = PH_END;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            SQ_RD_DATA:
            begin
                rdd_next = rd_ok ? sto_rdata : 8'h00;
            end
            default:
            begin
                cp_next = cp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SQ_IDLE;
            phase_reg  <= PH_IDLE;
            status_reg <= STAT_BUSY;
            bp_reg     <= '0;
            rem_reg    <= '0;
            hdr_reg    <= '0;
            vc_reg     <= '0;
            cp_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
            bp_reg     <= bp_next;
            rem_reg    <= rem_next;
            hdr_reg    <= hdr_next;
            vc_reg     <= vc_next;
            cp_reg     <= cp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cidx_reg <= cidx_next;
        item_reg <= item_next;
        rdd_reg  <= rdd_next;
        cm_reg   <= cm_next;
        cmc_reg  <= cmc_next;
        cmi_reg  <= cmi_next;
    end

`include "assert_macros.svh"

    `JDSP_ASSERT(a_rd_keeps_status, clk, rst_n,
        (state_reg == SQ_RD_DATA) |-> $stable(status_reg), "read item changed parse status")
    `JDSP_NEVER(a_copy_range, clk, rst_n,
        cp_reg > CP_LAST, "copy counter overran table size")
    `JDSP_ASSERT(a_values_bound, clk, rst_n,
        (state_reg == SQ_IDLE && phase_reg == PH_VALUES) |-> ({3'b0, bp_reg} < vc_reg),
        "value position reached value count while still in values")
    `JDSP_ASSERT(a_commit_from_seg, clk, rst_n,
        (result_valid && result.committed) |-> !item_reg.kind, "commit flagged on a read transfer")
    `JDSP_ASSERT(a_seg_to_exec, clk, rst_n,
        (item_valid && !item_stall && !item.kind) |=> (state_reg == SQ_EXEC),
        "segment byte transfer did not start execution")

endmodule

>>> src/jdsp_alu.sv
// Shared 16-bit add/subtract unit with borrow flag.
module jdsp_alu (
    input  jdsp_pkg::alu_req_t req,
    output jdsp_pkg::alu_rsp_t rsp
);
    import jdsp_pkg::*;

    logic             is_sub;
    logic [ALU_W-1:0] b_opnd;
    logic [ALU_W:0]   sum;

    assign is_sub = (req.op == ALU_SUB);
    assign b_opnd = is_sub ? ~req.b : req.b;
    assign sum    = {1'b0, req.a} + {1'b0, b_opnd} + {{ALU_W{1'b0}}, is_sub};

    assign rsp.res    = sum[ALU_W-1:0];
    assign rsp.borrow = is_sub & ~sum[ALU_W];

endmodule

>>> src/jdsp_stage.sv
// Staging area for one table: counts and values, value slots cleared by valid bits.
module jdsp_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  jdsp_pkg::stg_ctl_t ctl,
    output logic [7:0]         rdata
);
    import jdsp_pkg::*;

    logic [7:0]            mem [TBL_BYTES];
    logic [MAX_VALUES-1:0] valid_reg;
    logic [MAX_VALUES-1:0] valid_next;
    logic [7:0]            mem_rd_reg;
    logic                  zero_reg;
    logic                  zero_next;
    logic [STG_ADDR_W-1:0] wr_vpos;
    logic [STG_ADDR_W-1:0] rd_vpos;

    assign wr_vpos = ctl.waddr - STG_ADDR_W'(VAL_BASE);
    assign rd_vpos = ctl.raddr - STG_ADDR_W'(VAL_BASE);

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr)
        begin
            valid_next = '0;
        end
        else if (ctl.we && ctl.waddr >= STG_ADDR_W'(VAL_BASE))
        begin
            valid_next[wr_vpos[7:0]] = 1'b1;
        end
    end

    // entry 0 is always zero; a value slot not written since segment start reads zero
    assign zero_next = (ctl.raddr == '0) ||
                       ((ctl.raddr >= STG_ADDR_W'(VAL_BASE)) && !valid_reg[rd_vpos[7:0]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        mem_rd_reg <= mem[ctl.raddr];
        zero_reg   <= zero_next;
    end

    assign rdata = zero_reg ? 8'h00 : mem_rd_reg;

endmodule

>>> src/jdsp_store.sv
// Committed Huffman table store, one write and one registered read port.
module jdsp_store #(
    parameter int DEPTH = jdsp_pkg::STORE_DEPTH_DEF
) (
    input  logic                                    clk,
    input  jdsp_pkg::sto_wr_t                       wr,
    input  logic [jdsp_pkg::STO_ADDR_MAX_W-1:0]     raddr,
    output logic [7:0]                              rdata
);
    import jdsp_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
        rdata_reg <= mem[raddr[ADDR_W-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

>>> test/tb.sv
// Self-checking bench for the DHT segment parser core: item driver, result monitor, shadow parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jdsp_pkg::*;

    localparam int NT          = NUM_TABLES_DEF;
    localparam int STORE_BYTES = 2 * NT * TBL_BYTES;

    localparam logic KIND_SEG  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] MARKER_FF  = 8'hFF;
    localparam logic [7:0] MARKER_DHT = 8'hC4;

    localparam int ITEM_TARGET  = 450;
    localparam int IDLE_PCT     = 15;
    // long receiver hold-off, counted in cycles by the receiver itself
    localparam int HOLD_AT      = 1200;
    localparam int HOLD_LEN     = 300;
    // window with no idling on either side
    localparam int CALM_FROM    = 200;
    localparam int CALM_TO      = 1000;
    // every item returns a result, so the block is idle once the last one is in
    localparam int DRAIN_CYCLES = 50;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_stall;
    dht_in_t  item         = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    dht_out_t result;

    jpeg_dht_segment_parser_core #(
        .NUM_TABLES(NT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    // ------------------------------------------------------------------
    // Shadow parser state: same phases, lengths and stores as the block
    // ------------------------------------------------------------------
    phase_t     sh_phase  = PH_IDLE;
    logic [8:0] sh_pos    = '0;
    int         sh_remain = 0;
    logic [7:0] sh_header = '0;
    int         sh_vcount = 0;
    status_t    sh_status = STAT_BUSY;
    logic [7:0] sh_counts [1:NUM_COUNTS];
    logic [7:0] sh_values [0:MAX_VALUES-1];
    logic [7:0] sh_store  [0:STORE_BYTES-1];
    // tables committed so far; reads only ever target these
    bit         tbl_seen  [0:1][0:NT-1];

    dht_in_t    dht_items_q [$];    // items waiting to be driven
    dht_out_t   dht_results_q [$];  // predicted results, oldest first

    int   cycle_cnt    = 0;
    int   hold_left    = 0;
    int   mismatch_cnt = 0;
    int   items_sent   = 0;
    int   big_tables   = 0;
    logic item_taken   = 1'b0;
    logic idle_ok;

    assign idle_ok = !(cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO);

    function automatic void seg_fail();
        sh_status = STAT_ERR;
        sh_phase  = PH_END;
    endfunction

    // End of a table (or of the length field): done, error, or next header.
    function automatic void seg_boundary();
        if (sh_remain == 0)
        begin
            sh_status = STAT_DONE;
            sh_phase  = PH_END;
        end
        else if (sh_remain <= NUM_COUNTS)
            seg_fail();
        else
            sh_phase = PH_HEADER;
    endfunction

    // Copy counts and the full staging area into the store, unless the
    // table number is out of range.
    function automatic void commit_staged(inout dht_out_t r);
        int cls;
        int num;
        int base;
        cls = ((sh_header & AC_CLASS_MASK) != 8'h00) ? 1 : 0;
        num = int'(sh_header & ~AC_CLASS_MASK);
        if (num >= NT)
        begin
            seg_fail();
            return;
        end
        base = (cls * NT + num) * TBL_BYTES;
        sh_store[base] = 8'h00;
        for (int i = 1; i <= NUM_COUNTS; i++)
            sh_store[base + i] = sh_counts[i];
        for (int i = 0; i < MAX_VALUES; i++)
            sh_store[base + VAL_BASE + i] = sh_values[i];
        tbl_seen[cls][num] = 1'b1;
        r.committed       = 1'b1;
        r.committed_class = 1'(cls);
        r.committed_index = 2'(num);
        seg_boundary();
    endfunction

    // One transfer into the parser; returns the result it must produce.
    function automatic dht_out_t parse_dht_item(input dht_in_t it);
        dht_out_t r;
        int       addr;
        r = '0;
        if (it.kind == KIND_READ)
        begin
            if (int'(it.rd_table) < NT && int'(it.rd_pos) < TBL_BYTES)
            begin
                addr = (int'(it.rd_class) * NT + int'(it.rd_table)) * TBL_BYTES
                       + int'(it.rd_pos);
                r.read_data = sh_store[addr];
            end
        end
        else if (it.seg_start)
        begin
            // restart wherever we were; the byte itself is not looked at
            for (int i = 0; i < MAX_VALUES; i++)
                sh_values[i] = 8'h00;
            sh_status = STAT_BUSY;
            sh_phase  = PH_SKIP;
            sh_pos    = 9'd1;
            sh_remain = 0;
            sh_header = 8'h00;
            sh_vcount = 0;
        end
        else
        begin
            case (sh_phase)
                PH_SKIP:
                begin
                    sh_pos   = 9'd2;
                    sh_phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    sh_remain = int'(it.seg_byte) << 8;
                    sh_pos    = 9'd3;
                    sh_phase  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    sh_remain = sh_remain | int'(it.seg_byte);
                    sh_pos    = 9'd4;
                    if (sh_remain < int'(LEN_HDR_BYTES))
                        seg_fail();
                    else
                    begin
                        sh_remain -= int'(LEN_HDR_BYTES);
                        seg_boundary();
                    end
                end
                PH_HEADER:
                begin
                    sh_header = it.seg_byte;
                    sh_pos    = 9'd1;
                    sh_vcount = 0;
                    sh_phase  = PH_COUNTS;
                end
                PH_COUNTS:
                begin
                    sh_counts[sh_pos[4:0]] = it.seg_byte;
                    sh_vcount += int'(it.seg_byte);
                    if (int'(sh_pos) >= NUM_COUNTS)
                    begin
                        sh_remain -= int'(BOUND_LIMIT);
                        if (sh_vcount > MAX_VALUES || sh_vcount > sh_remain)
                            seg_fail();
                        else if (sh_vcount == 0)
                            commit_staged(r);
                        else
                        begin
                            sh_pos   = 9'd0;
                            sh_phase = PH_VALUES;
                        end
                    end
                    else
                        sh_pos++;
                end
                PH_VALUES:
                begin
                    sh_values[sh_pos[7:0]] = it.seg_byte;
                    sh_pos++;
                    if (int'(sh_pos) >= sh_vcount)
                    begin
                        sh_remain -= sh_vcount;
                        commit_staged(r);
                    end
                end
                default:
                    ;   // idle, done or error: byte ignored
            endcase
        end
        r.status = sh_status;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;   // non-blocking: the driver sees reset for this edge still
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each item transfer, checks each result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dht_out_t want;
        if (rst_n)
        begin
            cycle_cnt++;
            item_taken = item_valid && !item_stall;
            if (item_taken)
                dht_results_q.push_back(parse_dht_item(item));
            if (result_valid && !result_stall)
            begin
                if (dht_results_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: result with nothing outstanding, expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    want = dht_results_q.pop_front();
                    check_field("status", 8'(want.status), 8'(result.status));
                    check_field("read_data", want.read_data, result.read_data);
                    check_field("committed", 8'(want.committed), 8'(result.committed));
                    check_field("committed_class", 8'(want.committed_class),
                                8'(result.committed_class));
                    check_field("committed_index", 8'(want.committed_index),
                                8'(result.committed_index));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the next queued item once the current one transfers
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (dht_items_q.size() != 0 && !(idle_ok && $urandom_range(99, 0) < IDLE_PCT))
            begin
                item       <= dht_items_q.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (cycle_cnt == HOLD_AT)
        begin
            result_stall <= 1'b1;
            hold_left    <= HOLD_LEN;
        end
        else
            result_stall <= idle_ok && ($urandom_range(99, 0) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Keep the queue shallow so reads are chosen against recent commits.
    task automatic send_item(input dht_in_t it);
        while (dht_items_q.size() > 2)
            @(posedge clk);
        dht_items_q.push_back(it);
    endtask

    function automatic dht_in_t seg_item(input logic [7:0] b, input logic start);
        dht_in_t it;
        it.kind      = KIND_SEG;
        it.seg_byte  = b;
        it.seg_start = start;
        it.rd_class  = 1'($urandom);
        it.rd_table  = 2'($urandom);
        it.rd_pos    = 9'($urandom);
        return it;
    endfunction

    function automatic dht_in_t make_read(input logic cls, input logic [1:0] tbl,
                                          input logic [8:0] pos);
        dht_in_t it;
        it.kind      = KIND_READ;
        it.seg_byte  = 8'($urandom);
        it.seg_start = 1'($urandom);
        it.rd_class  = cls;
        it.rd_table  = tbl;
        it.rd_pos    = pos;
        return it;
    endfunction

    // Read one byte of a table that is already committed, if there is one.
    task automatic send_read();
        int picks [$];
        int k;
        int p;
        int r;
        for (int c = 0; c < 2; c++)
            for (int t = 0; t < NT; t++)
                if (tbl_seen[c][t])
                    picks.push_back(c * NT + t);
        if (picks.size() == 0)
            return;
        k = picks[$urandom_range(picks.size() - 1, 0)];
        r = $urandom_range(99, 0);
        if (r < 60)
            p = $urandom_range(TBL_BYTES - 1, 0);
        else if (r < 75)
        begin
            case ($urandom_range(3, 0))
                0:       p = 0;
                1:       p = NUM_COUNTS;
                2:       p = VAL_BASE;
                default: p = TBL_BYTES - 1;
            endcase
        end
        else if (r < 90)
            p = $urandom_range(511, TBL_BYTES);   // past the end: reads zero
        else
            p = $urandom_range(TBL_BYTES - 1, 256);
        send_item(make_read(1'(k / NT), 2'(k % NT), 9'(p)));
        items_sent++;
    endtask

    // Segment byte, now and then preceded by a read slipped in mid-segment.
    task automatic send_seg(input logic [7:0] b, input logic start);
        if ($urandom_range(99, 0) < 5)
            send_read();
        send_item(seg_item(b, start));
        items_sent++;
    endtask

    // One random DHT segment: mostly well formed, with bad headers, count
    // overflows, wrong lengths and truncation mixed in.
    task automatic gen_segment();
        logic [7:0]  body [$];
        logic [7:0]  cnt [1:NUM_COUNTS];
        logic [15:0] len16;
        int          ntab;
        int          nval;
        int          left;
        int          i;
        int          r;
        int          keep;
        bit          over;
        ntab = $urandom_range(3, 1);
        for (int t = 0; t < ntab; t++)
        begin
            r = $urandom_range(99, 0);
            if (r < 80)
                body.push_back({3'b000, 1'($urandom), 2'b00, 2'($urandom)});
            else if (r < 90)
                body.push_back({3'b000, 1'($urandom), 4'($urandom_range(15, 4))});
            else
                body.push_back(8'($urandom));
            over = ($urandom_range(99, 0) < 8);
            if (over)
                nval = 0;
            else if (big_tables < 2 && $urandom_range(99, 0) < 3)
            begin
                nval = MAX_VALUES;
                big_tables++;
            end
            else if ($urandom_range(3, 0) == 0)
                nval = 0;
            else
                nval = $urandom_range(24, 1);
            // overflow case: full-range counts, sum almost surely past 256
            for (i = 1; i <= NUM_COUNTS; i++)
                cnt[i] = over ? 8'($urandom) : 8'h00;
            left = nval;
            while (left > 0)
            begin
                i = $urandom_range(NUM_COUNTS, 1);
                if (cnt[i] != 8'hFF)
                begin
                    cnt[i]++;
                    left--;
                end
            end
            for (i = 1; i <= NUM_COUNTS; i++)
                body.push_back(cnt[i]);
            for (i = 0; i < nval; i++)
                body.push_back(8'($urandom));
            if (over)
                break;
        end

        r = $urandom_range(99, 0);
        if (r < 70)
            len16 = 16'(body.size() + 2);
        else if (r < 80)
            len16 = 16'(body.size() + 2 + $urandom_range(NUM_COUNTS, 1));
        else if (r < 86)
            len16 = 16'(body.size() + 2 + $urandom_range(65535 - body.size() - 2, 17));
        else if (r < 93)
            len16 = 16'(body.size() + 2
                        - $urandom_range((body.size() < 20) ? body.size() : 20, 1));
        else
            len16 = 16'($urandom_range(1, 0));

        keep = ($urandom_range(99, 0) < 8) ? $urandom_range(body.size(), 0) : body.size();

        send_seg(($urandom_range(99, 0) < 85) ? MARKER_FF : 8'($urandom), 1'b1);
        send_seg(($urandom_range(99, 0) < 85) ? MARKER_DHT : 8'($urandom), 1'b0);
        send_seg(len16[15:8], 1'b0);
        send_seg(len16[7:0], 1'b0);
        for (i = 0; i < keep; i++)
            send_seg(body[i], 1'b0);
        // trailing bytes, usually ignored after completion or error
        if ($urandom_range(99, 0) < 20)
            repeat ($urandom_range(3, 1))
                send_item(seg_item(8'($urandom), 1'b0));
        repeat ($urandom_range(3, 0))
            send_read();
    endtask

    task automatic wait_idle();
        while (dht_items_q.size() != 0 || item_valid || dht_results_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < MAX_VALUES; i++)
            sh_values[i] = 8'h00;
        for (int c = 0; c < 2; c++)
            for (int t = 0; t < NT; t++)
                tbl_seen[c][t] = 1'b0;

        // byte with no segment open: ignored
        send_seg(8'h00, 1'b0);
        // header length of one: error, and the byte after it is ignored
        send_seg(MARKER_FF, 1'b1);
        send_seg(MARKER_DHT, 1'b0);
        send_seg(8'h00, 1'b0);
        send_seg(8'h01, 1'b0);
        send_seg(8'hAB, 1'b0);
        // AC table 3, all counts zero: commits on its last count, segment complete
        send_seg(MARKER_FF, 1'b1);
        send_seg(MARKER_DHT, 1'b0);
        send_seg(8'h00, 1'b0);
        send_seg(8'h13, 1'b0);
        send_seg(8'h13, 1'b0);
        repeat (NUM_COUNTS)
            send_seg(8'h00, 1'b0);
        send_seg(MARKER_FF, 1'b0);
        wait_idle();
        send_item(make_read(1'b1, 2'd3, 9'd0));
        send_item(make_read(1'b1, 2'd3, 9'(NUM_COUNTS)));
        send_item(make_read(1'b1, 2'd3, 9'h1FF));
        items_sent += 3;

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(99, 0) < 5)
            begin
                // loose bytes, some with a stray start mark
                repeat ($urandom_range(6, 1))
                    send_item(seg_item(8'($urandom), ($urandom_range(99, 0) < 30)));
            end
            else
                gen_segment();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> jpeg_dht_segment_parser_core.f
+incdir+src
src/jdsp_pkg.sv
src/jdsp_alu.sv
src/jdsp_stage.sv
src/jdsp_store.sv
src/jpeg_dht_segment_parser_core.sv
test/tb.sv
